### rtl/vwo_pkg.sv
`default_nettype none

package vwo_pkg;

    localparam int CORNERS    = 4;
    localparam int CORNER_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_W     = 11;
    localparam int INC_W      = 27;
    localparam int PAD_W      = 17;
    localparam int MOD_W      = 18;
    localparam int SMOOTH_W   = 33;
    localparam int Q16_SHIFT  = 16;
    localparam int MIX_SHIFT  = 32;
    localparam int SMOOTH_COEF = 66;

    localparam logic [PAD_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PAD_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_TICK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_MIX   = 5'b01000,
        ST_HOLD  = 5'b10000
    } vwo_state_t;

    // tag that travels with a table read
    typedef struct packed {
        logic                vld;
        logic                upper;
        logic [CORNER_W-1:0] corner;
    } vwo_rd_tag_t;

    // tag that travels with an interpolated corner value
    typedef struct packed {
        logic                vld;
        logic [CORNER_W-1:0] corner;
    } vwo_val_tag_t;

endpackage

`default_nettype wire

### rtl/vwo_table_mem.sv
`default_nettype none

module vwo_table_mem #(
    parameter int MEM_AW = 13,
    parameter int MEM_DW = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [MEM_AW-1:0] waddr,
    input  wire logic [MEM_DW-1:0] wdata,
    input  wire logic              re,
    input  wire logic [MEM_AW-1:0] raddr,
    output logic      [MEM_DW-1:0] rdata
);

    logic [MEM_DW-1:0] mem [0:(1 << MEM_AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/vwo_interp.sv
`default_nettype none

module vwo_interp #(
    parameter int DW = 16,
    parameter int PF = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vwo_pkg::vwo_rd_tag_t rd_tag,
    input  wire logic signed [DW-1:0] rdata,
    input  wire logic [PF-1:0]        frac,
    output vwo_pkg::vwo_val_tag_t     val_tag,
    output logic signed [DW-1:0]      val
);

    import vwo_pkg::*;

    localparam int PRW = DW + PF + 2;

    logic signed [DW-1:0]  a_reg;
    logic signed [DW:0]    diff_reg;
    logic signed [DW-1:0]  base1_reg;
    logic signed [DW-1:0]  base2_reg;
    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] prod_shift;
    logic signed [DW:0]    sum;
    logic signed [DW-1:0]  val_reg;
    vwo_val_tag_t          s1_tag_reg;
    vwo_val_tag_t          s2_tag_reg;
    vwo_val_tag_t          s3_tag_reg;

    // first word of a pair is the lower sample, second is the next one
    always_ff @(posedge clk)
    begin
        if (rd_tag.vld && !rd_tag.upper)
        begin
            a_reg <= rdata;
        end
        if (rd_tag.vld && rd_tag.upper)
        begin
            diff_reg  <= (DW+1)'(rdata) - (DW+1)'(a_reg);
            base1_reg <= a_reg;
        end
        prod_reg  <= PRW'(diff_reg) * $signed(PRW'({1'b0, frac}));
        base2_reg <= base1_reg;
        val_reg   <= sum[DW-1:0];
    end

    always_comb
    begin
        prod_shift = prod_reg >>> PF;
        sum        = (DW+1)'(base2_reg) + prod_shift[DW:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg.vld    <= rd_tag.vld && rd_tag.upper;
            s1_tag_reg.corner <= rd_tag.corner;
            s2_tag_reg        <= s1_tag_reg;
            s3_tag_reg        <= s2_tag_reg;
        end
    end

    assign val_tag = s3_tag_reg;
    assign val     = val_reg;

endmodule

`default_nettype wire

### rtl/vwo_mix.sv
`default_nettype none

module vwo_mix #(
    parameter int DW = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DW-1:0]    v [vwo_pkg::CORNERS],
    input  wire logic [vwo_pkg::PAD_W-1:0] x,
    input  wire logic [vwo_pkg::PAD_W-1:0] y,
    output logic                         done,
    output logic signed [DW-1:0]         sample
);

    import vwo_pkg::*;

    localparam int LW  = DW + 19;
    localparam int ACW = LW + 19;

    logic signed [PAD_W:0]  xs;
    logic signed [PAD_W:0]  ys;
    logic signed [LW-1:0]   l_next;
    logic signed [LW-1:0]   r_next;
    logic signed [ACW-1:0]  acc;
    logic signed [LW-1:0]   l_reg;
    logic signed [LW-1:0]   r_reg;
    logic signed [LW-1:0]   lh_reg;
    logic signed [LW:0]     drl_reg;
    logic [PAD_W-1:0]       x1_reg;
    logic [PAD_W-1:0]       x2_reg;
    logic signed [DW-1:0]   sample_reg;
    logic                   s1_vld_reg;
    logic                   s2_vld_reg;
    logic                   done_reg;

    // left edge blends corners 0 and 1 along y, right edge corners 3 and 2
    always_comb
    begin
        ys     = $signed({1'b0, y});
        xs     = $signed({1'b0, x2_reg});
        l_next = (LW'(v[0]) <<< Q16_SHIFT) + LW'(ys) * LW'((DW+1)'(v[1]) - (DW+1)'(v[0]));
        r_next = (LW'(v[3]) <<< Q16_SHIFT) + LW'(ys) * LW'((DW+1)'(v[2]) - (DW+1)'(v[3]));
        acc    = (ACW'(lh_reg) <<< Q16_SHIFT) + ACW'(xs) * ACW'(drl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            l_reg  <= l_next;
            r_reg  <= r_next;
            x1_reg <= x;
        end
        if (s1_vld_reg)
        begin
            drl_reg <= (LW+1)'(r_reg) - (LW+1)'(l_reg);
            lh_reg  <= l_reg;
            x2_reg  <= x1_reg;
        end
        if (s2_vld_reg)
        begin
            sample_reg <= acc[MIX_SHIFT+DW-1:MIX_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

`default_nettype wire

### rtl/vwo_inc_reduce.sv
`default_nettype none

module vwo_inc_reduce #(
    parameter int TABLE_LENGTH        = 2048,
    parameter int PHASE_FRACTION_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire logic [vwo_pkg::INC_W-1:0] inc_in,
    output logic                           busy,
    output logic [$clog2(TABLE_LENGTH)+PHASE_FRACTION_BITS-1:0] inc_mod
);

    import vwo_pkg::*;

    localparam int AW = $clog2(TABLE_LENGTH);
    localparam int PF = PHASE_FRACTION_BITS;
    localparam int PW = AW + PF;
    localparam int HW = INC_W - PF;
    localparam int SH = HW + AW;
    localparam int RW = HW + 2;
    localparam int MW = HW + RW;
    localparam int QW = HW + AW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(TABLE_LENGTH) - 64'd1) / 64'(TABLE_LENGTH);
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

    logic [HW-1:0] hi_reg;
    logic [PF-1:0] lo_reg;
    logic [MW-1:0] prod_reg;
    logic [PW-1:0] rem_reg;
    logic          s1_reg;
    logic          s2_reg;
    logic [MW-1:0] quot_full;
    logic [HW-1:0] quot;
    logic [QW-1:0] back;
    logic [QW-1:0] rem_full;

    // integer part modulo table length by reciprocal multiply, fraction passes through
    always_comb
    begin
        quot_full = prod_reg >> SH;
        quot      = quot_full[HW-1:0];
        back      = QW'(quot) * QW'(TABLE_LENGTH);
        rem_full  = QW'(hi_reg) - back;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_reg <= inc_in[INC_W-1:PF];
            lo_reg <= inc_in[PF-1:0];
        end
        if (s1_reg)
        begin
            prod_reg <= MW'(hi_reg) * MW'(RECIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            s1_reg  <= 1'b0;
            s2_reg  <= 1'b0;
        end
        else
        begin
            s1_reg <= load;
            s2_reg <= s1_reg;
            if (s2_reg)
            begin
                rem_reg <= {rem_full[AW-1:0], lo_reg};
            end
        end
    end

    assign busy    = s1_reg || s2_reg;
    assign inc_mod = rem_reg;

endmodule

`default_nettype wire

### rtl/vector_wavetable_oscillator.sv
// Four-corner vector wavetable oscillator.
// Input channel (in_valid/in_ready) takes one word per item: command selects a
// table load or a sample tick. A load writes table_value into corner
// table_select at table_addr in the cycle it is accepted and gives no output;
// addresses at or beyond the table length are dropped.
// A tick reads all four corner tables at two neighboring positions through one
// memory read port, eight reads in sequence, interpolates, smooths the pad
// position, mixes bilinearly and gives one sample_out word on out_valid/out_ready.
// A new item is taken once the tick has left the datapath, so no item overlaps
// a tick; loads run at one per cycle while no config write is waiting or being
// reduced.
// Config channel (cfg_valid/cfg_ready) writes pad_x_target, pad_y_target and
// phase_increment by index. An increment write is reduced modulo the table
// span; while it is reduced, both input and config are held off.
// A stalled receiver leaves the finished sample in the output register; loads and
// one more tick may be taken; it runs through the mix before the block holds.
// Reset clears phase, smoothing state and config registers; table contents are
// undefined until loaded.
`default_nettype none

module vector_wavetable_oscillator #(
    parameter int TABLE_LENGTH        = 2048,
    parameter int SAMPLE_BITS         = 16,
    parameter int PHASE_FRACTION_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [vwo_pkg::CORNER_W-1:0]      table_select,
    input  wire logic [vwo_pkg::ADDR_W-1:0]        table_addr,
    input  wire logic signed [SAMPLE_BITS-1:0]     table_value,
    input  wire logic signed [vwo_pkg::MOD_W-1:0]  mod_x,
    input  wire logic signed [vwo_pkg::MOD_W-1:0]  mod_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]          sample_out,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vwo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    import vwo_pkg::*;

    localparam int AW  = $clog2(TABLE_LENGTH);
    localparam int PF  = PHASE_FRACTION_BITS;
    localparam int PW  = AW + PF;
    localparam int DW  = SAMPLE_BITS;
    localparam int MAW = AW + CORNER_W;
    localparam logic [PW:0] TOTAL = (PW+1)'(TABLE_LENGTH) << PF;

    vwo_state_t           state_reg;
    vwo_state_t           state_next;
    logic [2:0]           step_reg;
    logic [PW-1:0]        phase_reg;
    logic [SMOOTH_W-1:0]  smooth_x_reg;
    logic [SMOOTH_W-1:0]  smooth_y_reg;
    logic [PAD_W-1:0]     pad_x_reg;
    logic [PAD_W-1:0]     pad_y_reg;
    logic signed [MOD_W-1:0] mod_x_reg;
    logic signed [MOD_W-1:0] mod_y_reg;
    logic [PAD_W-1:0]     pos_x_reg;
    logic [PAD_W-1:0]     pos_y_reg;
    logic                 out_valid_reg;
    logic signed [DW-1:0] sample_reg;
    logic signed [DW-1:0] vals_reg [CORNERS-1];
    vwo_rd_tag_t          rd_tag_reg;

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 red_busy;
    logic [PW-1:0]        inc_mod;
    logic [31:0]          addr_ext;
    logic                 mem_we;
    logic [MAW-1:0]       mem_waddr;
    logic [MAW-1:0]       mem_raddr;
    logic [DW-1:0]        mem_rdata;
    logic [AW-1:0]        idx;
    logic [AW:0]          idx_p1;
    logic [AW-1:0]        nxt;
    vwo_val_tag_t         val_tag;
    logic signed [DW-1:0] interp_val;
    logic                 mix_start;
    logic                 mix_done;
    logic signed [DW-1:0] mix_sample;
    logic signed [DW-1:0] mix_v [CORNERS];
    logic                 load_out;
    logic [PW:0]          phase_sum;
    logic [PW:0]          phase_wrap;

    function automatic logic [SMOOTH_W-1:0] smooth_step(
        input logic [SMOOTH_W-1:0] s,
        input logic [PAD_W-1:0]    target
    );
        logic [PAD_W-1:0]            t;
        logic signed [SMOOTH_W:0]    d;
        logic signed [SMOOTH_W+7:0]  dm;
        logic signed [SMOOTH_W+7:0]  dstep;
        t     = (target > ONE_Q16) ? ONE_Q16 : target;
        d     = $signed({1'b0, t, {Q16_SHIFT{1'b0}}}) - $signed({1'b0, s});
        dm    = (SMOOTH_W+8)'(d) * $signed((SMOOTH_W+8)'(SMOOTH_COEF));
        dstep = dm >>> Q16_SHIFT;
        return s + dstep[SMOOTH_W-1:0];
    endfunction

    function automatic logic [PAD_W-1:0] pos_clamp(
        input logic [SMOOTH_W-1:0]     s,
        input logic signed [MOD_W-1:0] m
    );
        logic signed [MOD_W:0] p;
        logic [PAD_W-1:0]      r;
        p = $signed({2'b00, s[SMOOTH_W-1:Q16_SHIFT]}) + (MOD_W+1)'(m);
        if (p > $signed((MOD_W+1)'(ONE_Q16)))
        begin
            r = ONE_Q16;
        end
        else if (p < 0)
        begin
            r = '0;
        end
        else
        begin
            r = p[PAD_W-1:0];
        end
        return r;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE) && !red_busy && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !red_busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // table loads
    always_comb
    begin
        addr_ext  = 32'(table_addr);
        mem_we    = in_fire && (command == CMD_LOAD) && (addr_ext < 32'(TABLE_LENGTH));
        mem_waddr = {table_select, addr_ext[AW-1:0]};
    end

    // read sequence: lower then upper sample of each corner
    always_comb
    begin
        idx       = phase_reg[PW-1:PF];
        idx_p1    = {1'b0, idx} + 1'b1;
        nxt       = (idx_p1 >= (AW+1)'(TABLE_LENGTH)) ? '0 : idx_p1[AW-1:0];
        mem_raddr = {step_reg[2:1], step_reg[0] ? nxt : idx};
    end

    vwo_table_mem #(
        .MEM_AW (MAW),
        .MEM_DW (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (table_value),
        .re    (state_reg == ST_TICK),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vwo_interp #(
        .DW (DW),
        .PF (PF)
    ) u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_tag  (rd_tag_reg),
        .rdata   ($signed(mem_rdata)),
        .frac    (phase_reg[PF-1:0]),
        .val_tag (val_tag),
        .val     (interp_val)
    );

    assign mix_start = (state_reg == ST_DRAIN) && val_tag.vld && (val_tag.corner == CORNER_LAST);

    always_comb
    begin
        for (int i = 0; i < CORNERS - 1; i++)
        begin
            mix_v[i] = vals_reg[i];
        end
        mix_v[CORNERS-1] = interp_val;
    end

    vwo_mix #(
        .DW (DW)
    ) u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .v      (mix_v),
        .x      (pos_x_reg),
        .y      (pos_y_reg),
        .done   (mix_done),
        .sample (mix_sample)
    );

    vwo_inc_reduce #(
        .TABLE_LENGTH        (TABLE_LENGTH),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_inc (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cfg_fire && (cfg_index == REG_PHASE_INC)),
        .inc_in  (cfg_data[INC_W-1:0]),
        .busy    (red_busy),
        .inc_mod (inc_mod)
    );

    always_comb
    begin
        load_out   = ((state_reg == ST_MIX && mix_done) || state_reg == ST_HOLD)
                     && (!out_valid_reg || out_ready);
        phase_sum  = {1'b0, phase_reg} + {1'b0, inc_mod};
        phase_wrap = (phase_sum >= TOTAL) ? phase_sum - TOTAL : phase_sum;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command == CMD_TICK)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mix_start)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (mix_done)
                begin
                    state_next = load_out ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= '0;
            smooth_x_reg  <= '0;
            smooth_y_reg  <= '0;
            pad_x_reg     <= '0;
            pad_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TICK)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == ST_TICK && step_reg == 3'd0)
            begin
                smooth_x_reg <= smooth_step(smooth_x_reg, pad_x_reg);
                smooth_y_reg <= smooth_step(smooth_y_reg, pad_y_reg);
            end
            if (mix_start)
            begin
                phase_reg <= phase_wrap[PW-1:0];
            end
            if (cfg_fire && cfg_index == REG_PAD_X)
            begin
                pad_x_reg <= cfg_data[PAD_W-1:0];
            end
            if (cfg_fire && cfg_index == REG_PAD_Y)
            begin
                pad_y_reg <= cfg_data[PAD_W-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_tag_reg.vld    <= state_reg == ST_TICK;
            rd_tag_reg.upper  <= step_reg[0];
            rd_tag_reg.corner <= step_reg[2:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_TICK)
        begin
            mod_x_reg <= mod_x;
            mod_y_reg <= mod_y;
        end
        if (state_reg == ST_TICK && step_reg == 3'd1)
        begin
            pos_x_reg <= pos_clamp(smooth_x_reg, mod_x_reg);
            pos_y_reg <= pos_clamp(smooth_y_reg, mod_y_reg);
        end
        if (val_tag.vld && val_tag.corner != CORNER_LAST)
        begin
            vals_reg[val_tag.corner] <= interp_val;
        end
        if (load_out)
        begin
            sample_reg <= mix_sample;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

endmodule

`default_nettype wire

### rtl/vwo_checker.sv
`default_nettype none

module vwo_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              command,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [SAMPLE_BITS-1:0]     sample_out,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [vwo_pkg::CFG_IDX_W-1:0]     cfg_index
);

    import vwo_pkg::*;

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("output word changed while stalled");

    // a tick occupies the datapath, no second item next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_TICK |=> !in_ready)
        else $error("item accepted during tick");

    // no output appears in the cycle after an accept from an empty output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("output word appeared too early");

    // increment reduction blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == REG_PHASE_INC |=> !in_ready && !cfg_ready)
        else $error("item taken during increment reduction");

endmodule

bind vector_wavetable_oscillator vwo_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vwo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index)
);

`default_nettype wire

### dv/tb_vector_wavetable_oscillator.sv
`timescale 1ns / 100ps

module tb_vector_wavetable_oscillator;
    import vwo_pkg::*;

    localparam int     TABLE_LEN     = 2048;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     RANDOM_WORDS  = 500;
    localparam longint FULL_SCALE    = 64'sd65536;

    localparam logic signed [MOD_W-1:0] MOD_MAX = 18'sh1FFFF;
    localparam logic signed [MOD_W-1:0] MOD_MIN = 18'sh20000;
    localparam logic signed [MOD_W-1:0] MOD_ONE = 18'sd65536;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        command;
    logic [CORNER_W-1:0]         table_select;
    logic [ADDR_W-1:0]           table_addr;
    logic signed [15:0]          table_value;
    logic signed [MOD_W-1:0]     mod_x;
    logic signed [MOD_W-1:0]     mod_y;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [15:0]          sample_out;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [31:0]                 cfg_data;

    logic signed [15:0]          wave_mem [CORNERS][TABLE_LEN];
    bit                          loaded [CORNERS][TABLE_LEN];
    logic [INC_W-1:0]            phase_acc;
    logic [INC_W-1:0]            inc_reg;
    logic [SMOOTH_W-1:0]         glide_x;
    logic [SMOOTH_W-1:0]         glide_y;
    logic [PAD_W-1:0]            pad_x_reg;
    logic [PAD_W-1:0]            pad_y_reg;

    logic signed [15:0]          expected_samples [$];
    logic signed [15:0]          want_sample;
    int                          fail_count;
    int                          samples_checked;
    int                          words_sent;
    int                          ticks_sent;
    int                          reg_writes;
    int                          cycle_count;
    int                          idle_pct;
    int                          stall_pct;

    vector_wavetable_oscillator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .table_select (table_select),
        .table_addr   (table_addr),
        .table_value  (table_value),
        .mod_x        (mod_x),
        .mod_y        (mod_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [SMOOTH_W-1:0] glide_step(input logic [SMOOTH_W-1:0] s,
                                                       input logic [PAD_W-1:0] tgt);
        longint cur;
        longint goal;
        cur = longint'(s);
        if (tgt > ONE_Q16)
            goal = FULL_SCALE;
        else
            goal = longint'(tgt);
        goal = goal << Q16_SHIFT;
        cur  = cur + (((goal - cur) * SMOOTH_COEF) >>> Q16_SHIFT);
        return cur[SMOOTH_W-1:0];
    endfunction

    function automatic longint pad_position(input logic [SMOOTH_W-1:0] s,
                                            input logic signed [MOD_W-1:0] m);
        longint p;
        longint offset;
        p      = longint'(s >> Q16_SHIFT);
        offset = longint'(m);
        p      = p + offset;
        if (p > FULL_SCALE)
            p = FULL_SCALE;
        if (p < 0)
            p = 0;
        return p;
    endfunction

    function automatic void mix_next_sample(input logic signed [MOD_W-1:0] mx,
                                            input logic signed [MOD_W-1:0] my);
        longint            corner_val [CORNERS];
        longint            a;
        longint            b;
        longint            frac;
        longint            x;
        longint            y;
        longint            acc;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] nxt;
        glide_x = glide_step(glide_x, pad_x_reg);
        glide_y = glide_step(glide_y, pad_y_reg);
        idx  = phase_acc[INC_W-1:Q16_SHIFT];
        nxt  = idx + 1'b1;
        frac = longint'(phase_acc[Q16_SHIFT-1:0]);
        for (int c = 0; c < CORNERS; c++)
        begin
            a = longint'(wave_mem[c][idx]);
            b = longint'(wave_mem[c][nxt]);
            corner_val[c] = a + (((b - a) * frac) >>> Q16_SHIFT);
        end
        x = pad_position(glide_x, mx);
        y = pad_position(glide_y, my);
        acc = corner_val[0] * ((FULL_SCALE - x) * (FULL_SCALE - y))
            + corner_val[1] * ((FULL_SCALE - x) * y)
            + corner_val[2] * (x * y)
            + corner_val[3] * (x * (FULL_SCALE - y));
        acc = acc >>> MIX_SHIFT;
        expected_samples.push_back(acc[15:0]);
        phase_acc = phase_acc + inc_reg;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [MOD_W-1:0] rand_mod();
        int v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = $urandom_range(65536);
            2:
            begin
                case ($urandom_range(3))
                    0:       v = int'(MOD_MAX);
                    1:       v = int'(MOD_MIN);
                    2:       v = int'(MOD_ONE);
                    default: v = 0;
                endcase
            end
            default: v = int'($urandom_range(81920)) - 8192;
        endcase
        return MOD_W'(v);
    endfunction

    function automatic logic [31:0] rand_pad();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'(ONE_Q16);
            2:       return $urandom_range(131071, 65537);
            default: return $urandom_range(65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_increment();
        case ($urandom_range(3))
            0:       return $urandom_range(1 << 18);
            1:       return $urandom() & 32'h07FF_FFFF;
            2:       return $urandom_range(65535);
            default: return 32'h07FF_FFFF - $urandom_range(255);
        endcase
    endfunction

    task automatic send_word(input logic                    cmd,
                             input logic [CORNER_W-1:0]     sel,
                             input logic [ADDR_W-1:0]       addr,
                             input logic signed [15:0]      value,
                             input logic signed [MOD_W-1:0] mx,
                             input logic signed [MOD_W-1:0] my);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        table_select <= sel;
        table_addr   <= addr;
        table_value  <= value;
        mod_x        <= mx;
        mod_y        <= my;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (cmd == CMD_LOAD)
        begin
            wave_mem[sel][addr] = value;
            loaded[sel][addr]   = 1'b1;
        end
        else
        begin
            ticks_sent++;
            mix_next_sample(mx, my);
        end
    endtask

    task automatic load_word(input logic [CORNER_W-1:0] sel,
                             input logic [ADDR_W-1:0]   addr,
                             input logic signed [15:0]  value);
        send_word(CMD_LOAD, sel, addr, value, rand_mod(), rand_mod());
    endtask

    // loads any of the eight entries the next tick reads that are still unwritten
    task automatic tick_word(input logic signed [MOD_W-1:0] mx,
                             input logic signed [MOD_W-1:0] my);
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] nxt;
        idx = phase_acc[INC_W-1:Q16_SHIFT];
        nxt = idx + 1'b1;
        for (int c = 0; c < CORNERS; c++)
        begin
            if (!loaded[c][idx])
                load_word(CORNER_W'(c), idx, rand_sample());
            if (!loaded[c][nxt])
                load_word(CORNER_W'(c), nxt, rand_sample());
        end
        send_word(CMD_TICK, CORNER_W'($urandom()), ADDR_W'($urandom()), 16'($urandom()),
                  mx, my);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_PAD_X:     pad_x_reg = value[PAD_W-1:0];
            REG_PAD_Y:     pad_y_reg = value[PAD_W-1:0];
            REG_PHASE_INC: inc_reg   = value[INC_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] px, input logic [31:0] py,
                                  input logic [31:0] inc);
        write_reg(REG_PAD_X, px);
        write_reg(REG_PAD_Y, py);
        write_reg(REG_PHASE_INC, inc);
    endtask

    task automatic test_corner_extremes();
        for (int c = 0; c < CORNERS; c++)
        begin
            load_word(CORNER_W'(c), '0, (c % 2) ? 16'sh7FFF : 16'sh8000);
            load_word(CORNER_W'(c), ADDR_W'(TABLE_LEN - 1), (c % 2) ? 16'sh8000 : 16'sh7FFF);
        end
        tick_word('0, '0);
        tick_word(MOD_MAX, MOD_MAX);
        tick_word(MOD_MIN, MOD_MIN);
        tick_word(MOD_ONE, '0);
        tick_word('0, MOD_ONE);
    endtask

    task automatic test_register_sweep();
        // half-step below a whole table, so the second tick wraps its upper read to 0
        apply_settings(32'(ONE_Q16), 32'd0, {5'd0, 11'd2047, 16'h8000});
        repeat (3) tick_word(rand_mod(), rand_mod());
        apply_settings(32'h1FFFF, 32'h1FFFF, 32'h07FF_FFFF);
        repeat (4) tick_word(rand_mod(), rand_mod());
        apply_settings(32'd0, 32'(ONE_Q16), 32'd0);
        repeat (3) tick_word(rand_mod(), rand_mod());
        apply_settings($urandom_range(65536), $urandom_range(131071), 32'd1);
        repeat (3) tick_word(rand_mod(), rand_mod());
    endtask

    task automatic test_random_traffic();
        int start_words;
        int start_ticks;
        for (int m = 0; m < 4; m++)
        begin
            case (m)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default:
                begin
                    idle_pct  = 11;
                    stall_pct = 11;
                end
            endcase
            apply_settings(rand_pad(), rand_pad(), rand_increment());
            start_words = words_sent;
            start_ticks = ticks_sent;
            while (words_sent - start_words < RANDOM_WORDS / 4 ||
                   ticks_sent - start_ticks < 15)
            begin
                case ($urandom_range(39))
                    0:             hold_until_drained();
                    1, 2, 3, 4, 5,
                    6, 7, 8, 9:    load_word(CORNER_W'($urandom()), ADDR_W'($urandom()),
                                             rand_sample());
                    default:       tick_word(rand_mod(), rand_mod());
                endcase
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t unexpected sample_out word: expected none, actual %0d",
                         $time, sample_out);
                fail_count++;
            end
            else
            begin
                want_sample = expected_samples.pop_front();
                samples_checked++;
                if (sample_out !== want_sample)
                begin
                    $display("%0t sample_out mismatch: expected %0d, actual %0d",
                             $time, want_sample, sample_out);
                    fail_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles, %0d samples outstanding",
                 $time, cycle_count, expected_samples.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = CMD_TICK;
        table_select    = '0;
        table_addr      = '0;
        table_value     = '0;
        mod_x           = '0;
        mod_y           = '0;
        out_ready       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_PAD_X;
        cfg_data        = '0;
        phase_acc       = '0;
        inc_reg         = '0;
        glide_x         = '0;
        glide_y         = '0;
        pad_x_reg       = '0;
        pad_y_reg       = '0;
        fail_count      = 0;
        samples_checked = 0;
        words_sent      = 0;
        ticks_sent      = 0;
        reg_writes      = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_extremes();
        idle_pct  = 11;
        stall_pct = 11;
        test_register_sweep();
        test_random_traffic();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d words (%0d ticks) and %0d register writes under four idle/stall mixes",
                 words_sent, ticks_sent, reg_writes);
        $display("checked %0d samples, %0d failures", samples_checked, fail_count);
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
